### design/lr_pkg.sv
package lr_pkg;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 24;
    localparam int ERR_W   = 10;

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic [COLOR_W-1:0]      t_color;
    typedef logic signed [ERR_W-1:0] t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;
    } t_status;

endpackage

### design/lr_ctrl.sv
module lr_ctrl
    import lr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.at_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### design/lr_datapath.sv
module lr_datapath
    import lr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic    i_clk,
    input  t_cmd    i_cmd,
    input  t_coord  i_start_x,
    input  t_coord  i_start_y,
    input  t_coord  i_end_x,
    input  t_coord  i_end_y,
    input  t_color  i_color,
    output t_status o_status,
    output t_coord  o_pixel_x,
    output t_coord  o_pixel_y,
    output t_color  o_pixel_color,
    output logic    o_last_pixel
);

    localparam int     LIMIT = (GRID_SIZE > (1 << COORD_W)) ? ((1 << COORD_W) - 1)
                                                              : (GRID_SIZE - 1);
    localparam t_coord CLAMP = t_coord'(LIMIT);

    function automatic t_coord clamp_coord(input t_coord v);
        return (v > CLAMP) ? CLAMP : v;
    endfunction

    function automatic t_err to_err(input t_coord v);
        return t_err'({{(ERR_W-COORD_W){1'b0}}, v});
    endfunction

    // Captured segment.
    t_coord r_sx, r_sy, r_ex, r_ey;
    t_color r_color;

    // Walk state.
    t_coord r_major, r_minor, r_stop;
    t_coord r_dmaj, r_dmin;
    t_err   r_err;
    logic   r_down, r_steep;

    t_coord n_major, n_minor, n_stop, n_dmaj, n_dmin;
    t_err   n_err;
    logic   n_down, n_steep;

    t_coord adx, ady, a0, a1, b0, b1;
    logic [COORD_W:0] dmin_raw;
    logic [COORD_W:0] dmin_abs;

    // Segment setup: pick the major axis and order the endpoints upward along it.
    always_comb begin
        adx     = (r_ex > r_sx) ? (r_ex - r_sx) : (r_sx - r_ex);
        ady     = (r_ey > r_sy) ? (r_ey - r_sy) : (r_sy - r_ey);
        n_steep = !(ady < adx);
        if (n_steep) begin
            if (r_sy > r_ey) begin
                a0 = r_ey; a1 = r_sy; b0 = r_ex; b1 = r_sx;
            end else begin
                a0 = r_sy; a1 = r_ey; b0 = r_sx; b1 = r_ex;
            end
        end else begin
            if (r_sx > r_ex) begin
                a0 = r_ex; a1 = r_sx; b0 = r_ey; b1 = r_sy;
            end else begin
                a0 = r_sx; a1 = r_ex; b0 = r_sy; b1 = r_ey;
            end
        end
        dmin_raw = {1'b0, b1} - {1'b0, b0};
        n_down   = dmin_raw[COORD_W];
        dmin_abs = n_down ? (~dmin_raw + 1'b1) : dmin_raw;
    end

    always_comb begin
        n_major = r_major;
        n_minor = r_minor;
        n_stop  = r_stop;
        n_dmaj  = r_dmaj;
        n_dmin  = r_dmin;
        n_err   = r_err;
        if (i_cmd.setup) begin
            n_major = a0;
            n_minor = b0;
            n_stop  = a1;
            n_dmaj  = a1 - a0;
            n_dmin  = dmin_abs[COORD_W-1:0];
            n_err   = (to_err(dmin_abs[COORD_W-1:0]) <<< 1) - to_err(a1 - a0);
        end else if (i_cmd.step) begin
            n_major = r_major + t_coord'(1);
            if (r_err > t_err'(0)) begin
                n_minor = r_down ? (r_minor - t_coord'(1)) : (r_minor + t_coord'(1));
                n_err   = r_err + ((to_err(r_dmin) - to_err(r_dmaj)) <<< 1);
            end else begin
                n_err   = r_err + (to_err(r_dmin) <<< 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx    <= clamp_coord(i_start_x);
            r_sy    <= clamp_coord(i_start_y);
            r_ex    <= clamp_coord(i_end_x);
            r_ey    <= clamp_coord(i_end_y);
            r_color <= i_color;
        end
        if (i_cmd.setup) begin
            r_down  <= n_down;
            r_steep <= n_steep;
        end
        r_major <= n_major;
        r_minor <= n_minor;
        r_stop  <= n_stop;
        r_dmaj  <= n_dmaj;
        r_dmin  <= n_dmin;
        r_err   <= n_err;
    end

    assign o_status.at_end = (r_major == r_stop);
    assign o_pixel_x       = r_steep ? r_minor : r_major;
    assign o_pixel_y       = r_steep ? r_major : r_minor;
    assign o_pixel_color   = r_color;
    assign o_last_pixel    = (r_major == r_stop);

endmodule

### design/line_rasterizer.sv
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+-------------------------------------------
// in      | input     | i_in_valid / o_in_ready   | i_start_x, i_start_y, i_end_x, i_end_y, i_color
// out     | output    | o_out_valid / i_out_ready | o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel
//
// A segment is accepted by one transfer, set up, and then walked by the single
// Bresenham stepping unit, one pixel per cycle along the major axis unless the
// output stalls; a segment whose major span is N yields N + 1 pixels.
// One segment is handled at a time.
// Reset (i_rst_n, synchronous, active low) returns the controller to idle.
// A stall on the output holds the current pixel and freezes the walk.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    input  t_color i_color,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_coord o_pixel_x,
    output t_coord o_pixel_y,
    output t_color o_pixel_color,
    output logic   o_last_pixel
);

    // Commands and status between the sequencer and the stepping datapath.
    t_cmd    cmd;
    t_status status;

    // The controller accepts a segment only when idle, passes through a setup state,
    // and then presents one pixel per cycle, advancing on each output transfer.
    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the segment, the major and minor positions and the error
    // term; the pixel on the output comes straight from those registers.
    lr_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_color       (i_color),
        .o_status      (status),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
